/* rtl/gmp_pkg.sv */
package gmp_pkg;

   // Placement class codes as they arrive on the input channel
   localparam logic [3:0] CLS_NORMAL     = 4'd0;
   localparam logic [3:0] CLS_GLUE       = 4'd1;
   localparam logic [3:0] CLS_LEFT_GLUE  = 4'd2;
   localparam logic [3:0] CLS_RIGHT_GLUE = 4'd3;
   localparam logic [3:0] CLS_TOP_L      = 4'd4;
   localparam logic [3:0] CLS_TOP_C      = 4'd5;
   localparam logic [3:0] CLS_TOP_R      = 4'd6;
   localparam logic [3:0] CLS_BOT_L      = 4'd7;
   localparam logic [3:0] CLS_BOT_C      = 4'd8;
   localparam logic [3:0] CLS_BOT_R      = 4'd9;

   typedef enum logic [2:0] {
      OP_NORMAL,
      OP_GLUE,
      OP_LEFT_GLUE,
      OP_RIGHT_GLUE,
      OP_MARK_TOP,
      OP_MARK_BOTTOM,
      OP_NONE
   } op_kind_type;

   typedef enum logic [1:0] {
      ALIGN_LEFT,
      ALIGN_CENTER,
      ALIGN_RIGHT
   } align_type;

   // Decoded glyph as it sits in the queue between front and back
   typedef struct packed {
      logic        start_text;
      logic [7:0]  glyph_width;
      logic [7:0]  glyph_top;
      logic [7:0]  glyph_bottom;
      logic [7:0]  glyph_advance;
      op_kind_type op_kind;
      align_type   align;
   } item_type;

   typedef struct packed {
      logic        draw;
      logic [15:0] pos_x;
      logic [15:0] pos_y;
      logic [15:0] run_width;
   } result_type;

   // Handshake between a producer, a consumer and one of the small queues
   typedef struct packed {
      logic wr_en;
      logic rd_en;
   } fifo_ctl_type;

   typedef struct packed {
      logic full;
      logic empty;
   } fifo_stat_type;

endpackage

/* rtl/gmp_fifo.sv */
module gmp_fifo #(
   parameter int WIDTH = 8
) (
   input  logic                   clock,
   input  logic                   reset,
   input  gmp_pkg::fifo_ctl_type  ctl,
   input  logic [WIDTH-1:0]       wr_data,
   output gmp_pkg::fifo_stat_type stat,
   output logic [WIDTH-1:0]       rd_data
);

   // two entries: enough for one transfer per cycle with a registered flag
   logic [WIDTH-1:0] mem_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ ctl.wr_en;
      rd_ptr_in = rd_ptr_ff ^ ctl.rd_en;
      count_in  = count_ff + {1'b0, ctl.wr_en} - {1'b0, ctl.rd_en};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

   assign rd_data    = mem_ff[rd_ptr_ff];
   assign stat.full  = (count_ff == 2'd2);
   assign stat.empty = (count_ff == 2'd0);

endmodule

/* rtl/gmp_front.sv */
module gmp_front (
   input  logic              push,
   input  logic              q_full,
   input  logic              start_text,
   input  logic [7:0]        glyph_width,
   input  logic [7:0]        glyph_top,
   input  logic [7:0]        glyph_bottom,
   input  logic [7:0]        glyph_advance,
   input  logic [3:0]        glyph_class,
   output logic              q_wr_en,
   output gmp_pkg::item_type item
);

   assign q_wr_en = push & ~q_full;

   always_comb begin
      item.start_text    = start_text;
      item.glyph_width   = glyph_width;
      item.glyph_top     = glyph_top;
      item.glyph_bottom  = glyph_bottom;
      item.glyph_advance = glyph_advance;
      item.op_kind       = gmp_pkg::OP_NONE;
      item.align         = gmp_pkg::ALIGN_LEFT;
      case (glyph_class)
         gmp_pkg::CLS_NORMAL: begin
            item.op_kind = gmp_pkg::OP_NORMAL;
         end
         gmp_pkg::CLS_GLUE: begin
            item.op_kind = gmp_pkg::OP_GLUE;
         end
         gmp_pkg::CLS_LEFT_GLUE: begin
            item.op_kind = gmp_pkg::OP_LEFT_GLUE;
         end
         gmp_pkg::CLS_RIGHT_GLUE: begin
            item.op_kind = gmp_pkg::OP_RIGHT_GLUE;
         end
         gmp_pkg::CLS_TOP_L: begin
            item.op_kind = gmp_pkg::OP_MARK_TOP;
         end
         gmp_pkg::CLS_TOP_C: begin
            item.op_kind = gmp_pkg::OP_MARK_TOP;
            item.align   = gmp_pkg::ALIGN_CENTER;
         end
         gmp_pkg::CLS_TOP_R: begin
            item.op_kind = gmp_pkg::OP_MARK_TOP;
            item.align   = gmp_pkg::ALIGN_RIGHT;
         end
         gmp_pkg::CLS_BOT_L: begin
            item.op_kind = gmp_pkg::OP_MARK_BOTTOM;
         end
         gmp_pkg::CLS_BOT_C: begin
            item.op_kind = gmp_pkg::OP_MARK_BOTTOM;
            item.align   = gmp_pkg::ALIGN_CENTER;
         end
         gmp_pkg::CLS_BOT_R: begin
            item.op_kind = gmp_pkg::OP_MARK_BOTTOM;
            item.align   = gmp_pkg::ALIGN_RIGHT;
         end
         default: begin
            item.op_kind = gmp_pkg::OP_NONE;
         end
      endcase
   end

endmodule

/* rtl/gmp_back.sv */
module gmp_back #(
   parameter int POS_BITS = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic [7:0]          char_gap,
   input  logic                q_empty,
   input  gmp_pkg::item_type   item,
   input  logic                out_full,
   output logic                q_rd_en,
   output logic                out_wr_en,
   output gmp_pkg::result_type result
);

   logic [POS_BITS-1:0] pen_ff, pen_in;
   logic [POS_BITS-1:0] saved_ff, saved_in;
   logic [POS_BITS-1:0] bl_ff, bl_in;
   logic [POS_BITS-1:0] br_ff, br_in;
   logic [7:0]          bt_ff, bt_in;
   logic [7:0]          bb_ff, bb_in;
   logic                bv_ff, bv_in;
   logic [15:0]         wt_ff, wt_in;

   // state as seen by this glyph (start_text wipes it first)
   logic [POS_BITS-1:0] pen0, saved0, bl0, br0;
   logic [7:0]          bt0, bb0;
   logic                bv0;
   logic [15:0]         wt0;

   logic [POS_BITS-1:0] w_p, adv_p, gap_p;
   logic [POS_BITS-1:0] x, d, dn, half;
   logic [POS_BITS+15:0] x_wide;
   logic [15:0]         y;
   logic                draw;
   logic                fire;

   assign fire      = ~q_empty & ~out_full;
   assign q_rd_en   = fire;
   assign out_wr_en = fire;

   always_comb begin
      pen0   = item.start_text ? '0 : pen_ff;
      saved0 = item.start_text ? '0 : saved_ff;
      bl0    = item.start_text ? '0 : bl_ff;
      br0    = item.start_text ? '0 : br_ff;
      bt0    = item.start_text ? 8'd0 : bt_ff;
      bb0    = item.start_text ? 8'd0 : bb_ff;
      bv0    = item.start_text ? 1'b0 : bv_ff;
      wt0    = item.start_text ? 16'd0 : wt_ff;

      w_p   = {{(POS_BITS-8){1'b0}}, item.glyph_width};
      adv_p = {{(POS_BITS-8){1'b0}}, item.glyph_advance};
      gap_p = {{(POS_BITS-8){1'b0}}, char_gap};

      // centering offset, halved toward zero
      d    = br0 - bl0 - w_p;
      dn   = d + {{(POS_BITS-1){1'b0}}, d[POS_BITS-1]};
      half = {dn[POS_BITS-1], dn[POS_BITS-1:1]};

      pen_in   = pen0;
      saved_in = saved0;
      bl_in    = bl0;
      br_in    = br0;
      bt_in    = bt0;
      bb_in    = bb0;
      bv_in    = bv0;
      wt_in    = wt0;
      draw     = 1'b0;
      x        = '0;
      y        = 16'd0;

      case (item.op_kind)
         gmp_pkg::OP_NORMAL: begin
            draw     = 1'b1;
            x        = pen0;
            bv_in    = 1'b0;
            pen_in   = pen0 + w_p + gap_p;
            saved_in = pen0 + w_p + gap_p;
            wt_in    = wt0 + {8'd0, item.glyph_width} + {8'd0, char_gap};
         end
         gmp_pkg::OP_GLUE, gmp_pkg::OP_LEFT_GLUE, gmp_pkg::OP_RIGHT_GLUE: begin
            draw     = 1'b1;
            // right glue sits flush with the end of its advance
            x        = (item.op_kind == gmp_pkg::OP_RIGHT_GLUE) ? pen0 + adv_p - w_p : pen0;
            bt_in    = item.glyph_top;
            bb_in    = item.glyph_bottom;
            bv_in    = 1'b1;
            bl_in    = pen0;
            br_in    = pen0 + ((item.op_kind == gmp_pkg::OP_GLUE) ? w_p : adv_p);
            pen_in   = pen0 + adv_p;
            saved_in = pen0 + adv_p;
            wt_in    = wt0 + {8'd0, item.glyph_advance};
         end
         gmp_pkg::OP_MARK_TOP, gmp_pkg::OP_MARK_BOTTOM: begin
            pen_in = saved0;
            if (bv0) begin
               draw = 1'b1;
               if (item.op_kind == gmp_pkg::OP_MARK_TOP) begin
                  y = {8'd0, bt0} - ({8'd0, item.glyph_bottom} - {8'd0, item.glyph_top});
               end else begin
                  y = {8'd0, bb0};
               end
               case (item.align)
                  gmp_pkg::ALIGN_LEFT:   x = bl0;
                  gmp_pkg::ALIGN_CENTER: x = bl0 + half;
                  gmp_pkg::ALIGN_RIGHT:  x = br0 - w_p;
                  default:               x = bl0;
               endcase
            end
         end
         default: begin
            pen_in = saved0;
         end
      endcase

      x_wide           = {16'd0, x};
      result.draw      = draw;
      result.pos_x     = x_wide[15:0];
      result.pos_y     = y;
      result.run_width = wt_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pen_ff   <= '0;
         saved_ff <= '0;
         bl_ff    <= '0;
         br_ff    <= '0;
         bt_ff    <= 8'd0;
         bb_ff    <= 8'd0;
         bv_ff    <= 1'b0;
         wt_ff    <= 16'd0;
      end else if (fire) begin
         pen_ff   <= pen_in;
         saved_ff <= saved_in;
         bl_ff    <= bl_in;
         br_ff    <= br_in;
         bt_ff    <= bt_in;
         bb_ff    <= bb_in;
         bv_ff    <= bv_in;
         wt_ff    <= wt_in;
      end
   end

endmodule

/* rtl/glyph_mark_placement_core.sv */
// A push goes through the item queue and back end to the result (empty low).
// Throughput: one glyph per cycle while the result queue has room; the state
// update in the back end is the loop that sets that rate.
// Reset: synchronous, active high; empties both queues, clears pen, saved
// position, base rectangle, running width and char_gap.
module glyph_mark_placement_core #(
   parameter int POS_BITS = 16
) (
   input  logic               clock,
   input  logic               reset,
   // configuration
   input  logic               csr_wr_en,
   input  logic [7:0]         csr_wr_data,
   // input queue side
   input  logic               push,
   output logic               full,
   input  logic               req_start_text,
   input  logic [7:0]         req_glyph_width,
   input  logic [7:0]         req_glyph_top,
   input  logic [7:0]         req_glyph_bottom,
   input  logic [7:0]         req_glyph_advance,
   input  logic [3:0]         req_glyph_class,
   // result queue side
   output logic               empty,
   input  logic               pop,
   output logic               rsp_draw,
   output logic signed [15:0] rsp_pos_x,
   output logic signed [15:0] rsp_pos_y,
   output logic [15:0]        rsp_run_width
);

   localparam int ItemBits   = $bits(gmp_pkg::item_type);
   localparam int ResultBits = $bits(gmp_pkg::result_type);

   // char_gap: the user must write it only while the block is idle; the block does not enforce this
   logic [7:0] char_gap_ff, char_gap_in;

   assign char_gap_in = csr_wr_en ? csr_wr_data : char_gap_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         char_gap_ff <= 8'd0;
      end else begin
         char_gap_ff <= char_gap_in;
      end
   end

   // front end: decode the class into an op and an alignment
   gmp_pkg::item_type      front_item;
   gmp_pkg::item_type      head_item;
   logic [ItemBits-1:0]    head_bits;
   gmp_pkg::fifo_ctl_type  iq_ctl;
   gmp_pkg::fifo_stat_type iq_stat;

   gmp_front u_front (
      .push          (push),
      .q_full        (iq_stat.full),
      .start_text    (req_start_text),
      .glyph_width   (req_glyph_width),
      .glyph_top     (req_glyph_top),
      .glyph_bottom  (req_glyph_bottom),
      .glyph_advance (req_glyph_advance),
      .glyph_class   (req_glyph_class),
      .q_wr_en       (iq_ctl.wr_en),
      .item          (front_item)
   );

   // decoupling queue between front and back
   gmp_fifo #(
      .WIDTH (ItemBits)
   ) u_item_q (
      .clock   (clock),
      .reset   (reset),
      .ctl     (iq_ctl),
      .wr_data (front_item),
      .stat    (iq_stat),
      .rd_data (head_bits)
   );

   assign head_item = gmp_pkg::item_type'(head_bits);

   // back end: placement state and arithmetic, one glyph per transfer
   gmp_pkg::result_type    back_result;
   gmp_pkg::result_type    out_result;
   logic [ResultBits-1:0]  out_bits;
   gmp_pkg::fifo_ctl_type  oq_ctl;
   gmp_pkg::fifo_stat_type oq_stat;

   gmp_back #(
      .POS_BITS (POS_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .char_gap  (char_gap_ff),
      .q_empty   (iq_stat.empty),
      .item      (head_item),
      .out_full  (oq_stat.full),
      .q_rd_en   (iq_ctl.rd_en),
      .out_wr_en (oq_ctl.wr_en),
      .result    (back_result)
   );

   // result queue: while it is full, the back end waits for a pop
   assign oq_ctl.rd_en = pop & ~oq_stat.empty;

   gmp_fifo #(
      .WIDTH (ResultBits)
   ) u_result_q (
      .clock   (clock),
      .reset   (reset),
      .ctl     (oq_ctl),
      .wr_data (back_result),
      .stat    (oq_stat),
      .rd_data (out_bits)
   );

   assign out_result    = gmp_pkg::result_type'(out_bits);
   assign full          = iq_stat.full;
   assign empty         = oq_stat.empty;
   assign rsp_draw      = out_result.draw;
   assign rsp_pos_x     = $signed(out_result.pos_x);
   assign rsp_pos_y     = $signed(out_result.pos_y);
   assign rsp_run_width = out_result.run_width;

endmodule

/* rtl/gmp_checker.sv */
module gmp_checker (
   input logic               clock,
   input logic               reset,
   input logic               full,
   input logic               empty,
   input logic               pop,
   input logic               rsp_draw,
   input logic signed [15:0] rsp_pos_x,
   input logic signed [15:0] rsp_pos_y,
   input logic [15:0]        rsp_run_width
);

   // both queues come out of reset empty
   a_reset_empty: assert property (@(posedge clock)
      reset |=> (empty && !full))
      else $error("queues not empty after reset");

   // a glyph that is not drawn reports the origin
   a_nodraw_zero: assert property (@(posedge clock) disable iff (reset)
      (!empty && !rsp_draw) |-> (rsp_pos_x == 16'sd0 && rsp_pos_y == 16'sd0))
      else $error("undrawn glyph with nonzero position");

   // a result that is not taken stays put: its x position and run width hold
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop) |=> (!empty && $stable(rsp_run_width) && $stable(rsp_pos_x)))
      else $error("waiting result changed");

endmodule

bind glyph_mark_placement_core gmp_checker u_gmp_checker (.*);

/* bench/glyph_mark_placement_core_tb.sv */
module glyph_mark_placement_core_tb;

   localparam int POS_BITS       = 16;
   localparam int LATENCY        = 1;      // margin added when draining results
   localparam int HOLD_CYCLES    = 150;    // long receiver hold-off
   localparam int MAX_REPORTS    = 10;
   localparam int TIMEOUT_CYCLES = 200_000;

   // classes 10..15 carry no meaning; the block must skip them
   localparam logic [3:0] CLS_UNDEF_FIRST = 4'd10;
   localparam int         UNDEF_COUNT     = 6;

   typedef logic [POS_BITS-1:0] pos_type;

   typedef struct packed {
      logic       start_text;
      logic [7:0] width;
      logic [7:0] top;
      logic [7:0] bottom;
      logic [7:0] advance;
      logic [3:0] cls;
   } glyph_type;

   // ---------------------------------------------------------------
   // DUT signals; the inputs are known from time zero
   // ---------------------------------------------------------------
   logic               clock             = 1'b0;
   logic               reset             = 1'b1;
   logic               csr_wr_en         = 1'b0;
   logic [7:0]         csr_wr_data       = '0;
   logic               push              = 1'b0;
   logic               full;
   logic               req_start_text    = 1'b0;
   logic [7:0]         req_glyph_width   = '0;
   logic [7:0]         req_glyph_top     = '0;
   logic [7:0]         req_glyph_bottom  = '0;
   logic [7:0]         req_glyph_advance = '0;
   logic [3:0]         req_glyph_class   = '0;
   logic               empty;
   logic               pop               = 1'b0;
   logic               rsp_draw;
   logic signed [15:0] rsp_pos_x;
   logic signed [15:0] rsp_pos_y;
   logic [15:0]        rsp_run_width;

   glyph_mark_placement_core #(
      .POS_BITS (POS_BITS)
   ) uut (
      .clock             (clock),
      .reset             (reset),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data),
      .push              (push),
      .full              (full),
      .req_start_text    (req_start_text),
      .req_glyph_width   (req_glyph_width),
      .req_glyph_top     (req_glyph_top),
      .req_glyph_bottom  (req_glyph_bottom),
      .req_glyph_advance (req_glyph_advance),
      .req_glyph_class   (req_glyph_class),
      .empty             (empty),
      .pop               (pop),
      .rsp_draw          (rsp_draw),
      .rsp_pos_x         (rsp_pos_x),
      .rsp_pos_y         (rsp_pos_y),
      .rsp_run_width     (rsp_run_width)
   );

   always #5 clock = ~clock;

   // ---------------------------------------------------------------
   // Placement state mirrored by the bench
   // ---------------------------------------------------------------
   pos_type     pen, pen_saved, base_l, base_r;
   logic [7:0]  base_t, base_b;
   logic        has_base;
   logic [15:0] text_width;
   logic [7:0]  gap_px;

   gmp_pkg::result_type pending_placements[$];   // one per accepted glyph, oldest first
   int unsigned mismatch_count = 0;
   int unsigned glyphs_sent    = 0;

   logic        idle_on    = 1'b1;   // random gaps on both sides
   logic        drain_hold = 1'b0;   // receiver holds off while set
   logic        rsp_moved  = 1'b0;   // result transfer at the last rising edge
   int unsigned pop_delay  = 0;

   // Works out where one glyph lands and advances the mirrored state.
   function automatic gmp_pkg::result_type place_glyph(input glyph_type g);
      gmp_pkg::result_type        r;
      pos_type                    x;
      logic signed [POS_BITS-1:0] span;
      r = '0;
      x = '0;
      if (g.start_text) begin
         pen        = '0;
         pen_saved  = '0;
         base_l     = '0;
         base_r     = '0;
         base_t     = '0;
         base_b     = '0;
         has_base   = 1'b0;
         text_width = '0;
      end
      if (g.cls <= gmp_pkg::CLS_RIGHT_GLUE) begin
         // bases: drawn on the baseline, pen moves on
         r.draw = 1'b1;
         if (g.cls == gmp_pkg::CLS_RIGHT_GLUE)
            pen = pen + pos_type'(g.advance) - pos_type'(g.width);
         x = pen;
         if (g.cls == gmp_pkg::CLS_NORMAL) begin
            // normal glyph drops the base but keeps its rectangle
            has_base   = 1'b0;
            pen        = pen + pos_type'(g.width) + pos_type'(gap_px);
            text_width = text_width + 16'(g.width) + 16'(gap_px);
         end else begin
            base_t   = g.top;
            base_b   = g.bottom;
            has_base = 1'b1;
            if (g.cls == gmp_pkg::CLS_RIGHT_GLUE) begin
               base_l = pen + pos_type'(g.width) - pos_type'(g.advance);
               base_r = pen + pos_type'(g.width);
               pen    = base_r;
            end else begin
               base_l = pen;
               base_r = pen + pos_type'((g.cls == gmp_pkg::CLS_GLUE) ? g.width : g.advance);
               pen    = pen + pos_type'(g.advance);
            end
            text_width = text_width + 16'(g.advance);
         end
         pen_saved = pen;
      end else begin
         // marks hang on the last glue base; nothing drawn without one
         if (g.cls <= gmp_pkg::CLS_BOT_R && has_base) begin
            r.draw = 1'b1;
            if (g.cls <= gmp_pkg::CLS_TOP_R)
               r.pos_y = 16'(base_t) - (16'(g.bottom) - 16'(g.top));
            else
               r.pos_y = 16'(base_b);
            case (g.cls)
               gmp_pkg::CLS_TOP_L, gmp_pkg::CLS_BOT_L: x = base_l;
               gmp_pkg::CLS_TOP_C, gmp_pkg::CLS_BOT_C: begin
                  // signed halving, truncates toward zero
                  span = base_r - base_l - pos_type'(g.width);
                  x    = base_l + pos_type'(span / 2);
               end
               default: x = base_r - pos_type'(g.width);
            endcase
         end
         pen = pen_saved;
      end
      r.pos_x     = x[15:0];
      r.run_width = text_width;
      return r;
   endfunction

   function automatic int unsigned idle_draw();
      return idle_on ? $urandom_range(0, 4) : 0;
   endfunction

   // mostly random, with the byte extremes showing up often
   function automatic logic [7:0] pick_metric();
      case ($urandom_range(0, 9))
         0:       return 8'd0;
         1:       return 8'd255;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic glyph_type random_glyph(input logic [3:0] cls);
      glyph_type  g;
      logic [7:0] a, b;
      a            = pick_metric();
      b            = pick_metric();
      g.start_text = 1'b0;
      g.width      = pick_metric();
      g.advance    = pick_metric();
      g.cls        = cls;
      // ink rows usually ordered, now and then upside down
      if ((a <= b) ^ ($urandom_range(0, 7) == 0)) begin
         g.top    = a;
         g.bottom = b;
      end else begin
         g.top    = b;
         g.bottom = a;
      end
      return g;
   endfunction

   task automatic report_failure(input string msg);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS)
         $display("%s", msg);
   endtask

   // ---------------------------------------------------------------
   // Sender: one glyph per call, returns at the falling edge after the
   // transfer with push still up
   // ---------------------------------------------------------------
   task automatic push_glyph(input glyph_type g);
      int unsigned gap;
      gap = idle_draw();
      if (gap != 0) begin
         push <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      push              <= 1'b1;
      req_start_text    <= g.start_text;
      req_glyph_width   <= g.width;
      req_glyph_top     <= g.top;
      req_glyph_bottom  <= g.bottom;
      req_glyph_advance <= g.advance;
      req_glyph_class   <= g.cls;
      do @(posedge clock); while (full);
      pending_placements.push_back(place_glyph(g));
      glyphs_sent++;
      @(negedge clock);
   endtask

   // Stop offering and let every expected result come out.
   task automatic drain_results();
      push <= 1'b0;
      while (pending_placements.size() != 0) @(negedge clock);
      repeat (LATENCY + 2) @(negedge clock);
   endtask

   task automatic write_char_gap(input logic [7:0] value);
      drain_results();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      gap_px = value;
   endtask

   // ---------------------------------------------------------------
   // Receiver: pop held until a transfer, then a random stall
   // ---------------------------------------------------------------
   always @(negedge clock) begin : drain_side
      int unsigned stall;
      if (reset || drain_hold) begin
         pop       <= 1'b0;
         pop_delay <= 0;
      end else if (rsp_moved) begin
         stall = idle_draw();
         pop       <= (stall == 0);
         pop_delay <= (stall == 0) ? 0 : stall - 1;
      end else if (!pop) begin
         if (pop_delay != 0)
            pop_delay <= pop_delay - 1;
         else
            pop <= 1'b1;
      end
   end

   // Every result transfer is held against the oldest expectation.
   always @(posedge clock) begin : placement_check
      gmp_pkg::result_type want;
      rsp_moved = 1'b0;
      if (!reset && pop && !empty) begin
         rsp_moved = 1'b1;
         if (pending_placements.size() == 0) begin
            report_failure($sformatf(
               "unexpected result: draw=%0b x=%0d y=%0d width=%0d",
               rsp_draw, rsp_pos_x, rsp_pos_y, rsp_run_width));
         end else begin
            want = pending_placements.pop_front();
            if (rsp_draw !== want.draw || rsp_pos_x !== want.pos_x ||
                rsp_pos_y !== want.pos_y || rsp_run_width !== want.run_width)
               report_failure($sformatf(
                  {"mismatch: expected draw=%0b x=%0d y=%0d width=%0d,",
                   " got draw=%0b x=%0d y=%0d width=%0d"},
                  want.draw, $signed(want.pos_x), $signed(want.pos_y),
                  want.run_width, rsp_draw, rsp_pos_x, rsp_pos_y, rsp_run_width));
         end
      end
   end

   // ---------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------

   // Field extremes, every class, marks with no base, odd and negative
   // centring spans, pen going below zero, undefined classes. Runs with
   // char_gap at its reset value.
   task automatic test_directed_cases();
      push_glyph('{1'b1, 8'd0,   8'd0,   8'd0,   8'd0,   gmp_pkg::CLS_NORMAL});
      push_glyph('{1'b0, 8'd255, 8'd255, 8'd255, 8'd255, gmp_pkg::CLS_NORMAL});
      push_glyph('{1'b0, 8'd8,   8'd2,   8'd6,   8'd0,   gmp_pkg::CLS_TOP_C});   // no base
      push_glyph('{1'b0, 8'd10,  8'd20,  8'd40,  8'd12,  gmp_pkg::CLS_GLUE});
      push_glyph('{1'b0, 8'd4,   8'd0,   8'd3,   8'd0,   gmp_pkg::CLS_TOP_L});
      push_glyph('{1'b0, 8'd31,  8'd1,   8'd9,   8'd0,   gmp_pkg::CLS_TOP_C});   // span -21
      push_glyph('{1'b0, 8'd3,   8'd9,   8'd1,   8'd0,   gmp_pkg::CLS_TOP_R});   // rows swapped
      push_glyph('{1'b0, 8'd255, 8'd0,   8'd255, 8'd0,   gmp_pkg::CLS_BOT_L});
      push_glyph('{1'b0, 8'd5,   8'd0,   8'd0,   8'd0,   gmp_pkg::CLS_BOT_C});   // span 5
      push_glyph('{1'b0, 8'd0,   8'd0,   8'd0,   8'd0,   gmp_pkg::CLS_BOT_R});
      push_glyph('{1'b0, 8'd5,   8'd255, 8'd0,   8'd255, gmp_pkg::CLS_LEFT_GLUE});
      push_glyph('{1'b0, 8'd0,   8'd7,   8'd200, 8'd0,   gmp_pkg::CLS_TOP_C});   // span 255
      push_glyph('{1'b0, 8'd200, 8'd3,   8'd250, 8'd3,   gmp_pkg::CLS_RIGHT_GLUE});
      push_glyph('{1'b0, 8'd17,  8'd30,  8'd60,  8'd0,   gmp_pkg::CLS_BOT_C});   // span -14
      push_glyph('{1'b0, 8'd0,   8'd0,   8'd0,   8'd255, gmp_pkg::CLS_RIGHT_GLUE});
      push_glyph('{1'b0, 8'd1,   8'd0,   8'd0,   8'd0,   gmp_pkg::CLS_TOP_R});
      for (int i = 0; i < UNDEF_COUNT; i++)
         push_glyph('{1'b0, 8'd9, 8'd1, 8'd2, 8'd3, 4'(CLS_UNDEF_FIRST + i)});
      push_glyph('{1'b1, 8'd9,   8'd4,   8'd8,   8'd6,   gmp_pkg::CLS_BOT_L});   // cleared base
      push_glyph('{1'b1, 8'd255, 8'd0,   8'd0,   8'd0,   gmp_pkg::CLS_RIGHT_GLUE}); // pen < 0
      push_glyph('{1'b0, 8'd2,   8'd0,   8'd0,   8'd0,   gmp_pkg::CLS_NORMAL});
   endtask

   // Well-formed text: a base followed by a few marks, words now and
   // then starting a fresh line; long runs let the pen wrap.
   task automatic test_random_words(input int unsigned glyph_goal);
      int unsigned stop_at, clusters;
      glyph_type   g;
      stop_at = glyphs_sent + glyph_goal;
      while (glyphs_sent < stop_at) begin
         clusters = $urandom_range(1, 6);
         for (int c = 0; c < clusters; c++) begin
            g = random_glyph(4'($urandom_range(gmp_pkg::CLS_NORMAL,
                                               gmp_pkg::CLS_RIGHT_GLUE)));
            g.start_text = (c == 0) && ($urandom_range(0, 3) == 0);
            push_glyph(g);
            repeat ($urandom_range(0, 3))
               push_glyph(random_glyph(4'($urandom_range(gmp_pkg::CLS_TOP_L,
                                                         gmp_pkg::CLS_BOT_R))));
         end
      end
   endtask

   // Walk char_gap through its extremes and two values in between.
   task automatic test_char_gap_settings();
      write_char_gap(8'd255);
      test_random_words(170);
      write_char_gap(8'd0);
      test_random_words(170);
      write_char_gap(8'($urandom_range(2, 254)));
      test_random_words(170);
      write_char_gap(8'd1);
      test_random_words(170);
   endtask

   // Unordered glyph soup, including the odd undefined class.
   task automatic test_noise(input int unsigned count);
      glyph_type g;
      write_char_gap(8'($urandom_range(0, 255)));
      repeat (count) begin
         if ($urandom_range(0, 7) == 0)
            g = random_glyph(4'($urandom_range(CLS_UNDEF_FIRST, 15)));
         else
            g = random_glyph(4'($urandom_range(gmp_pkg::CLS_NORMAL, gmp_pkg::CLS_BOT_R)));
         g.start_text = ($urandom_range(0, 7) == 0);
         push_glyph(g);
      end
   endtask

   // Both sides at full rate.
   task automatic test_back_to_back(input int unsigned count);
      write_char_gap(8'($urandom_range(0, 255)));
      idle_on = 1'b0;
      test_random_words(count);
      idle_on = 1'b1;
   endtask

   // Receiver goes quiet for a long stretch while glyphs keep coming,
   // so both queues fill and full must hold off the sender.
   task automatic test_full_stall(input int unsigned count);
      write_char_gap(8'($urandom_range(0, 255)));
      idle_on = 1'b0;
      fork
         begin
            @(posedge clock);
            drain_hold = 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            drain_hold = 1'b0;
         end
         repeat (count)
            push_glyph(random_glyph(4'($urandom_range(gmp_pkg::CLS_NORMAL,
                                                      gmp_pkg::CLS_BOT_R))));
      join
      idle_on = 1'b1;
   endtask

   initial begin : run_tests
      pen        = '0;
      pen_saved  = '0;
      base_l     = '0;
      base_r     = '0;
      base_t     = '0;
      base_b     = '0;
      has_base   = 1'b0;
      text_width = '0;
      gap_px     = '0;
      repeat (8) @(negedge clock);
      reset <= 1'b0;

      test_directed_cases();
      test_char_gap_settings();
      test_noise(220);
      test_back_to_back(100);
      test_full_stall(80);

      drain_results();
      if (mismatch_count == 0 && pending_placements.size() == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

   // Hang guard: far beyond the slowest legal run.
   initial begin : watchdog
      #(TIMEOUT_CYCLES * 10);
      $display("== FAIL ==");
      $finish;
   end

endmodule
